[src/iirdf1_pkg.sv]
// Shared types and constants for the direct-form I IIR filter core.
package iirdf1_pkg;

   localparam int TAPS_DEFAULT = 4;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 18;
   localparam int A0_W        = 17;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int NUM_REGS    = 8;
   localparam int NUM_FF_REGS = 4;

   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
   localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
   localparam int TERM_COEF_W = COEF_W + 1;
   localparam int PROD_W     = TERM_COEF_W + DIGIT_W + 1;

   localparam int QUO_W     = A0_W;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

   localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;
   localparam logic [A0_W-1:0]          A0_RESET = 17'd16384;

   typedef enum logic [2:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_B3 = 3'd3,
      REG_A0 = 3'd4,
      REG_A1 = 3'd5,
      REG_A2 = 3'd6,
      REG_A3 = 3'd7
   } reg_idx_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MAC   = 7'b0000010,
      ST_ABS   = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_SAT   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

[src/iir_direct_form_one_filter_core.sv]
// Direct-form I IIR filter core: digit-serial MAC, bit-serial divide, APB coefficient port.
// Steps: a MAC phase over 2*TAPS-1 terms (one 4-bit digit of the sample per cycle through a
// 19x5 multiplier), magnitude and range check states, a restoring divide (one quotient
// bit per cycle), a saturation state and an output state.
// A new word is taken only when idle; a zero or out-of-range quotient skips the divide.
// Reset clears sample and output history and loads b0 = a0 = 16384, other coefficients 0.
module iir_direct_form_one_filter_core
   import iirdf1_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                         rsp_saturated,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam int HIST      = TAPS - 1;
   localparam int NUM_TERMS = 2 * TAPS - 1;
   localparam int TERM_W    = $clog2(NUM_TERMS);
   localparam int ACC_W     = SAMPLE_W + COEF_W + $clog2(NUM_TERMS);

   // coefficient registers
   logic signed [COEF_W-1:0] coef_b_ff [NUM_FF_REGS];
   logic signed [COEF_W-1:0] coef_a_ff [1:NUM_FF_REGS-1];
   logic [A0_W-1:0]          coef_a0_ff;

   logic        csr_wr;
   reg_idx_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i < NUM_FF_REGS; i++) coef_b_ff[i] <= '0;
         for (int i = 1; i < NUM_FF_REGS; i++) coef_a_ff[i] <= '0;
         coef_b_ff[0] <= B0_RESET;
         coef_a0_ff   <= A0_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_B0:  coef_b_ff[0] <= pwdata[COEF_W-1:0];
            REG_B1:  coef_b_ff[1] <= pwdata[COEF_W-1:0];
            REG_B2:  coef_b_ff[2] <= pwdata[COEF_W-1:0];
            REG_B3:  coef_b_ff[3] <= pwdata[COEF_W-1:0];
            REG_A0:  coef_a0_ff   <= pwdata[A0_W-1:0];
            REG_A1:  coef_a_ff[1] <= pwdata[COEF_W-1:0];
            REG_A2:  coef_a_ff[2] <= pwdata[COEF_W-1:0];
            REG_A3:  coef_a_ff[3] <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_B0:  prdata = CSR_DATA_W'(coef_b_ff[0]);
         REG_B1:  prdata = CSR_DATA_W'(coef_b_ff[1]);
         REG_B2:  prdata = CSR_DATA_W'(coef_b_ff[2]);
         REG_B3:  prdata = CSR_DATA_W'(coef_b_ff[3]);
         REG_A0:  prdata = CSR_DATA_W'(coef_a0_ff);
         REG_A1:  prdata = CSR_DATA_W'(coef_a_ff[1]);
         REG_A2:  prdata = CSR_DATA_W'(coef_a_ff[2]);
         REG_A3:  prdata = CSR_DATA_W'(coef_a_ff[3]);
         default: prdata = '0;
      endcase
   end

   // datapath registers
   state_type                     state_ff, state_in;
   logic signed [SAMPLE_W-1:0]    x_ff;
   logic signed [SAMPLE_W-1:0]    xh_ff [HIST];
   logic signed [SAMPLE_W-1:0]    yh_ff [HIST];
   logic [TERM_W-1:0]             term_ff;
   logic [DIG_IDX_W-1:0]          digit_ff;
   logic [SAMPLE_W-1:0]           samp_ff;
   logic signed [TERM_COEF_W-1:0] cur_coef_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic [ACC_W-1:0]              mag_ff;
   logic                          neg_ff;
   logic [A0_W-1:0]               rem_ff;
   logic [QUO_W-1:0]              dvd_ff;
   logic [DIV_CNT_W-1:0]          div_cnt_ff;
   logic signed [SAMPLE_W-1:0]    res_ff;
   logic                          res_sat_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]    rsp_sample_ff;
   logic                          rsp_sat_ff;

   logic                          req_take;
   logic                          done_fire;
   logic [TERM_W-1:0]             sel_idx;
   logic signed [TERM_COEF_W-1:0] sel_coef;
   logic [SAMPLE_W-1:0]           sel_samp;
   logic signed [DIGIT_W:0]       dig;
   logic signed [PROD_W-1:0]      prod;
   logic signed [ACC_W-1:0]       prod_sh;
   logic [ACC_W-1:0]              a0_lim;
   logic [A0_W+1:0]               trial;
   logic [QUO_W-1:0]              neg_q;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // next term operand select; term 0 is loaded from the incoming word
   assign sel_idx = (state_ff == ST_IDLE) ? '0 : term_ff + TERM_W'(1);

   always_comb begin
      sel_coef = TERM_COEF_W'(coef_b_ff[0]);
      sel_samp = req_sample_in;
      for (int i = 1; i < TAPS; i++) begin
         if (sel_idx == TERM_W'(i)) begin
            sel_coef = TERM_COEF_W'(coef_b_ff[i]);
            sel_samp = xh_ff[i-1];
         end
         if (sel_idx == TERM_W'(TAPS - 1 + i)) begin
            sel_coef = -TERM_COEF_W'(coef_a_ff[i]);
            sel_samp = yh_ff[i-1];
         end
      end
   end

   // top digit of the sample is signed
   assign dig = (digit_ff == DIG_IDX_W'(NUM_DIGITS - 1)) ?
                {samp_ff[DIGIT_W-1], samp_ff[DIGIT_W-1:0]} :
                {1'b0, samp_ff[DIGIT_W-1:0]};
   assign prod    = cur_coef_ff * dig;
   assign prod_sh = ACC_W'(prod) <<< {digit_ff, 2'b00};

   assign a0_lim = ACC_W'(coef_a0_ff) << QUO_W;
   assign trial  = {1'b0, rem_ff, dvd_ff[QUO_W-1]} - {2'b00, coef_a0_ff};
   assign neg_q  = '0 - dvd_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_MAC;
         ST_MAC:   if (digit_ff == DIG_IDX_W'(NUM_DIGITS - 1) &&
                       term_ff == TERM_W'(NUM_TERMS - 1)) state_in = ST_ABS;
         ST_ABS:   state_in = ST_CHECK;
         ST_CHECK: state_in = (mag_ff == '0 || mag_ff >= a0_lim) ? ST_DONE : ST_DIV;
         ST_DIV:   if (div_cnt_ff == DIV_CNT_W'(QUO_W - 1)) state_in = ST_SAT;
         ST_SAT:   state_in = ST_DONE;
         ST_DONE:  if (done_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HIST; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (done_fire) begin
            for (int i = HIST - 1; i > 0; i--) begin
               xh_ff[i] <= xh_ff[i-1];
               yh_ff[i] <= yh_ff[i-1];
            end
            xh_ff[0] <= x_ff;
            yh_ff[0] <= res_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x_ff        <= req_sample_in;
            samp_ff     <= sel_samp;
            cur_coef_ff <= sel_coef;
            term_ff     <= '0;
            digit_ff    <= '0;
            acc_ff      <= '0;
         end
         ST_MAC: begin
            acc_ff   <= acc_ff + prod_sh;
            digit_ff <= digit_ff + DIG_IDX_W'(1);
            if (digit_ff == DIG_IDX_W'(NUM_DIGITS - 1)) begin
               term_ff     <= sel_idx;
               samp_ff     <= sel_samp;
               cur_coef_ff <= sel_coef;
            end else begin
               samp_ff <= samp_ff >> DIGIT_W;
            end
         end
         ST_ABS: begin
            neg_ff <= acc_ff[ACC_W-1];
            mag_ff <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         end
         ST_CHECK: begin
            rem_ff     <= mag_ff[QUO_W +: A0_W];
            dvd_ff     <= mag_ff[QUO_W-1:0];
            div_cnt_ff <= '0;
            res_sat_ff <= (mag_ff != '0);
            if (mag_ff == '0) begin
               res_ff <= '0;
            end else begin
               res_ff <= neg_ff ? OUT_MIN : OUT_MAX;
            end
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            if (!trial[A0_W+1]) begin
               rem_ff <= trial[A0_W-1:0];
            end else begin
               rem_ff <= {rem_ff[A0_W-2:0], dvd_ff[QUO_W-1]};
            end
            dvd_ff <= {dvd_ff[QUO_W-2:0], !trial[A0_W+1]};
         end
         ST_SAT: begin
            if (!neg_ff) begin
               res_sat_ff <= |dvd_ff[QUO_W-1:SAMPLE_W-1];
               res_ff     <= (|dvd_ff[QUO_W-1:SAMPLE_W-1]) ? OUT_MAX : dvd_ff[SAMPLE_W-1:0];
            end else if (dvd_ff > QUO_W'(1 << (SAMPLE_W - 1))) begin
               res_sat_ff <= 1'b1;
               res_ff     <= OUT_MIN;
            end else begin
               res_sat_ff <= 1'b0;
               res_ff     <= neg_q[SAMPLE_W-1:0];
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_sample_ff <= res_ff;
               rsp_sat_ff    <= res_sat_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
